// ===== hw/rtl/breakpoint_table_matcher_core_assert.svh =====
// Assertion macros for the breakpoint table matcher.
// Each macro takes a label, the clock, the active-low reset and the terms.
`ifndef BREAKPOINT_TABLE_MATCHER_CORE_ASSERT_SVH
`define BREAKPOINT_TABLE_MATCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BPTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("breakpoint table matcher: assertion failed");

// Next-cycle implication.
`define BPTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("breakpoint table matcher: assertion failed");

`else

`define BPTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/bptm_pkg.sv =====
package bptm_pkg;

  localparam int BPTM_NUM_SLOTS = 16;

  localparam int ADDR_W   = 32;
  localparam int OP_W     = 3;
  localparam int SIDX_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  localparam logic [OP_W-1:0] OP_CHECK     = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD       = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_ADDR  = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_SLOT  = 3'd3;
  localparam logic [OP_W-1:0] OP_ARM_STEP  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_SET = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  // Per-cell control: load the broadcast address, or take the upper neighbour.
  typedef struct packed {
    logic              load;
    logic              shift;
    logic [ADDR_W-1:0] addr;
  } bptm_cell_ctrl_t;

endpackage

// ===== hw/rtl/bptm_cell.sv =====
module bptm_cell
  import bptm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  bptm_cell_ctrl_t   ctrl,
  input  logic [ADDR_W-1:0] nbr_addr,
  input  logic              nbr_used,
  input  logic [ADDR_W-1:0] probe_addr,
  output logic [ADDR_W-1:0] addr_r,
  output logic              used_r,
  output logic              match
);

  logic [ADDR_W-1:0] addr_nxt;
  logic              used_nxt;

  always_comb begin
    addr_nxt = addr_r;
    used_nxt = used_r;
    if (ctrl.load) begin
      addr_nxt = ctrl.addr;
      used_nxt = 1'b1;
    end else if (ctrl.shift) begin
      addr_nxt = nbr_addr;
      used_nxt = nbr_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      used_r <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      used_r <= used_nxt;
    end
  end

  assign match = used_r && (addr_r == probe_addr);

endmodule

// ===== hw/rtl/breakpoint_table_matcher_core.sv =====
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready  | tdata: address, slot_index; tuser: operation
// out_    | out | out_tvalid/out_tready| tdata: hit, status, slot
//
// One request per cycle while the output register is not stalled: every request
// is decoded, compared against all cells and committed in the cycle it is accepted;
// its result appears in the output register on the next cycle. The compare row has
// one address comparator per cell. Synchronous active-low reset empties the table
// and drops the step flag. A stalled result holds in the output register; a new
// request is taken in the same cycle the held result is taken.

`include "breakpoint_table_matcher_core_assert.svh"

module breakpoint_table_matcher_core
  import bptm_pkg::*;
#(
  parameter int NUM_SLOTS = BPTM_NUM_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] address, [39:32] slot_index
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] hit, [3:1] status, [9:4] slot, [15:10] zero
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Unpack the request.
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] addr;
  logic [SIDX_W-1:0] sidx;

  assign op   = in_tuser;
  assign addr = in_tdata[ADDR_W-1:0];
  assign sidx = in_tdata[ADDR_W +: SIDX_W];

  logic accept;
  assign accept = in_tvalid && in_tready;

  // Row of cells; cell i takes cell i+1's entry on a removal at or below it.
  bptm_cell_ctrl_t   ctrl     [NUM_SLOTS];
  logic [ADDR_W-1:0] cell_addr[NUM_SLOTS];
  logic              cell_used[NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_vec;
  logic [NUM_SLOTS-1:0] match_vec;

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      logic [ADDR_W-1:0] up_addr;
      logic              up_used;
      if (g == NUM_SLOTS - 1) begin : g_top
        assign up_addr = '0;
        assign up_used = 1'b0;
      end else begin : g_mid
        assign up_addr = cell_addr[g+1];
        assign up_used = cell_used[g+1];
      end
      bptm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl[g]),
        .nbr_addr   (up_addr),
        .nbr_used   (up_used),
        .probe_addr (addr),
        .addr_r     (cell_addr[g]),
        .used_r     (cell_used[g]),
        .match      (match_vec[g])
      );
      assign used_vec[g] = cell_used[g];
    end
  endgenerate

  // The table has no gaps and no duplicates, so the match row is one-hot or
  // empty and the first free slot is the single used-to-free boundary.
  logic [NUM_SLOTS-1:0] free_vec;
  logic [SW-1:0]        hit_idx;
  logic [SW-1:0]        free_idx;
  logic                 found;
  logic                 full;
  logic                 sidx_used;
  logic                 sidx_range;

  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    sidx_used = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free_vec[i] = !used_vec[i] && ((i == 0) || used_vec[(i > 0) ? i - 1 : 0]);
      if (match_vec[i]) hit_idx  = hit_idx  | SW'(i);
      if (free_vec[i])  free_idx = free_idx | SW'(i);
      if (sidx == SIDX_W'(i)) sidx_used = sidx_used | used_vec[i];
    end
  end

  assign found      = |match_vec;
  assign full       = used_vec[NUM_SLOTS-1];
  assign sidx_range = (sidx >= SIDX_W'(NUM_SLOTS));

  // Decode the operation into cell controls and the result.
  logic                step_armed_r, step_armed_nxt;
  logic                do_load;
  logic                do_remove;
  logic [SW-1:0]       rem_idx;
  logic                res_hit;
  logic [STATUS_W-1:0] res_status;
  logic [SW-1:0]       res_slot;

  always_comb begin
    step_armed_nxt = step_armed_r;
    do_load        = 1'b0;
    do_remove      = 1'b0;
    rem_idx        = hit_idx;
    res_hit        = 1'b0;
    res_status     = ST_OK;
    res_slot       = '0;
    case (op)
      OP_CHECK: begin
        if (step_armed_r) begin
          step_armed_nxt = 1'b0;
          res_hit        = 1'b1;
        end else if (found) begin
          res_hit  = 1'b1;
          res_slot = hit_idx;
        end
      end
      OP_ADD: begin
        if (found) begin
          res_status = ST_ALREADY;
          res_slot   = hit_idx;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_load  = 1'b1;
          res_slot = free_idx;
        end
      end
      OP_REM_ADDR: begin
        if (!found) begin
          res_status = ST_NOT_SET;
        end else begin
          do_remove = 1'b1;
          res_slot  = hit_idx;
        end
      end
      OP_REM_SLOT: begin
        rem_idx = sidx[SW-1:0];
        if (sidx_range) begin
          res_status = ST_RANGE;
        end else if (!sidx_used) begin
          res_status = ST_NOT_SET;
        end else begin
          do_remove = 1'b1;
          res_slot  = sidx[SW-1:0];
        end
      end
      OP_ARM_STEP: begin
        step_armed_nxt = 1'b1;
      end
      default: begin
        // Unknown operation: no change, all-zero result.
      end
    endcase
  end

  // Fan the decision out to the row: load the free slot, shift from the
  // removed slot upward.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ctrl[i].addr  = addr;
      ctrl[i].load  = accept && do_load && free_vec[i];
      ctrl[i].shift = accept && do_remove && (SW'(i) >= rem_idx);
    end
  end

  // Output register; advance when empty or when the held result is taken.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r,  out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0, SLOT_W'(res_slot), res_status, res_hit};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_armed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) step_armed_r <= step_armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // No address is ever held twice.
  `BPTM_ASSERT_IMP(a_match_onehot, clk, rst_n, 1'b1, $onehot0(match_vec))
  // Used entries stay packed at the bottom of the table.
  `BPTM_ASSERT_IMP(a_used_packed, clk, rst_n, 1'b1, ((used_vec >> 1) & ~used_vec) == '0)
  // An armed step fires on the next check and then clears.
  `BPTM_ASSERT_NEXT(a_step_fires, clk, rst_n,
                    accept && (op == OP_CHECK) && step_armed_r,
                    out_tvalid && out_tdata[0] && !step_armed_r)
  // Every accepted request leaves a result in the output register.
  `BPTM_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_valid_r)

endmodule

// ===== bench/breakpoint_table_matcher_core_tb.sv =====
`timescale 1ns / 1ps

module breakpoint_table_matcher_core_tb;
  import bptm_pkg::*;

  localparam int NUM_SLOTS = BPTM_NUM_SLOTS;

  // The fields of one result as the block reports them.
  typedef struct packed {
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } bp_outcome_t;

  // Scoreboard: keeps its own copy of the breakpoint table and the step flag,
  // predicts the outcome of each accepted request and checks results in order.
  class breakpoint_scoreboard;
    logic [ADDR_W-1:0] bp_addr_tab [NUM_SLOTS];
    logic              bp_in_use [NUM_SLOTS];
    logic              step_pending;
    bp_outcome_t       expected_outcomes [$];
    int                errors;
    int                results_checked;
    int                hits_seen;
    int                status_seen [5];

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bp_addr_tab[i] = '0;
        bp_in_use[i] = 1'b0;
      end
      step_pending = 1'b0;
      errors = 0;
      results_checked = 0;
      hits_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Search stops at the first empty slot: the table is kept compacted.
    function int find_entry(logic [ADDR_W-1:0] a);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!bp_in_use[i]) return -1;
        if (bp_addr_tab[i] == a) return i;
      end
      return -1;
    endfunction

    function int first_empty();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!bp_in_use[i]) return i;
      end
      return -1;
    endfunction

    // Drop entry idx and close the gap from above.
    function void drop_entry(int idx);
      for (int i = idx; i < NUM_SLOTS - 1; i++) begin
        bp_addr_tab[i] = bp_addr_tab[i + 1];
        bp_in_use[i] = bp_in_use[i + 1];
      end
      bp_addr_tab[NUM_SLOTS - 1] = '0;
      bp_in_use[NUM_SLOTS - 1] = 1'b0;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // Note an accepted request: advance the table and queue its outcome.
    function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                               logic [SIDX_W-1:0] sidx);
      bp_outcome_t o;
      int          k;
      o = '0;
      case (op)
        OP_CHECK: begin
          if (step_pending) begin
            step_pending = 1'b0;
            o.hit = 1'b1;
          end else begin
            k = find_entry(a);
            if (k >= 0) begin
              o.hit = 1'b1;
              o.slot = SLOT_W'(k);
            end
          end
        end
        OP_ADD: begin
          k = find_entry(a);
          if (k >= 0) begin
            o.status = ST_ALREADY;
            o.slot = SLOT_W'(k);
          end else begin
            k = first_empty();
            if (k < 0) begin
              o.status = ST_FULL;
            end else begin
              bp_addr_tab[k] = a;
              bp_in_use[k] = 1'b1;
              o.slot = SLOT_W'(k);
            end
          end
        end
        OP_REM_ADDR: begin
          k = find_entry(a);
          if (k < 0) begin
            o.status = ST_NOT_SET;
          end else begin
            drop_entry(k);
            o.slot = SLOT_W'(k);
          end
        end
        OP_REM_SLOT: begin
          if (int'(sidx) >= NUM_SLOTS) begin
            o.status = ST_RANGE;
          end else if (!bp_in_use[sidx]) begin
            o.status = ST_NOT_SET;
          end else begin
            drop_entry(int'(sidx));
            o.slot = SLOT_W'(sidx);
          end
        end
        OP_ARM_STEP: begin
          step_pending = 1'b1;
        end
        default: begin
        end
      endcase
      expected_outcomes.push_back(o);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    // Compare one accepted result, field by field, with the oldest outcome.
    task check_result(logic [15:0] tdata);
      bp_outcome_t want;
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result", int'(tdata), 0);
      end else begin
        want = expected_outcomes.pop_front();
        results_checked++;
        if (tdata[0] !== want.hit) report_mismatch("hit", int'(tdata[0]), int'(want.hit));
        if (tdata[3:1] !== want.status)
          report_mismatch("status", int'(tdata[3:1]), int'(want.status));
        if (tdata[9:4] !== want.slot) report_mismatch("slot", int'(tdata[9:4]), int'(want.slot));
        if (tdata[15:10] !== '0) report_mismatch("padding", int'(tdata[15:10]), 0);
        if (want.hit) hits_seen++;
        if (int'(want.status) < 5) status_seen[want.status]++;
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [31:0] address, [39:32] slot_index
  logic [2:0]  in_tuser = '0;    // [2:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [0] hit, [3:1] status, [9:4] slot, [15:10] zero

  breakpoint_scoreboard sb = new();

  int requests_sent = 0;
  logic [ADDR_W-1:0] addr_pool [20];

  breakpoint_table_matcher_core #(
    .NUM_SLOTS (NUM_SLOTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one request; return at the edge that accepts it. Inputs only move at
  // the rising edge, so the handshake is sampled safely at the falling edge.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                              input logic [SIDX_W-1:0] sidx);
    logic taken;
    // Idle now and then, except within a steady stretch of requests.
    while ($urandom_range(0, 99) < 22 && !(requests_sent >= 200 && requests_sent < 300)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sidx, a};
    in_tuser  <= op;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    sb.note_request(op, a, sidx);
    requests_sent++;
  endtask

  // Hold the sender until every outstanding result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void refresh_pool();
    foreach (addr_pool[i]) addr_pool[i] = $urandom();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, 19)];
    return $urandom();
  endfunction

  function automatic logic [SIDX_W-1:0] pick_slot_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return SIDX_W'($urandom_range(0, 255));
    if (r < 30) return SIDX_W'($urandom_range(0, NUM_SLOTS + 1));
    return SIDX_W'($urandom_range(0, NUM_SLOTS - 1));
  endfunction

  // Random requests drawn from a small address pool, so that adds collide,
  // checks hit, and the table both fills and empties. Weights are cumulative.
  task automatic random_phase(input int n, input int w_check, input int w_add,
                              input int w_rem_addr, input int w_rem_slot, input int w_arm);
    int               r;
    logic [OP_W-1:0]  op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_check) op = OP_CHECK;
      else if (r < w_add) op = OP_ADD;
      else if (r < w_rem_addr) op = OP_REM_ADDR;
      else if (r < w_rem_slot) op = OP_REM_SLOT;
      else if (r < w_arm) op = OP_ARM_STEP;
      else op = OP_W'($urandom_range(5, 7));
      send_request(op, pick_address(), pick_slot_index());
    end
  endtask

  // Receiver: stall at random, once hold off for a long stretch so the output
  // register fills and the block stalls its input, and check what is taken.
  initial begin : receiver
    int results_taken;
    int hold_left;
    bit hold_done;
    results_taken = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_taken >= 120) begin
        hold_done = 1'b1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (results_taken >= 200 && results_taken < 300) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 22);
      end
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        results_taken++;
      end
    end
  end

  initial begin : stimulus
    int settle;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of the address, every operation, the special cases.
    send_request(OP_CHECK,    32'h0000_0000, 8'd0);   // empty table, no match
    send_request(OP_ADD,      32'h0000_0000, 8'd0);
    send_request(OP_ADD,      32'hFFFF_FFFF, 8'hFF);
    send_request(OP_ADD,      32'h0000_0000, 8'd0);   // already present
    send_request(OP_CHECK,    32'h0000_0000, 8'd0);
    send_request(OP_CHECK,    32'hFFFF_FFFF, 8'd0);
    send_request(OP_CHECK,    32'h8000_0001, 8'd0);   // no match
    send_request(OP_ARM_STEP, 32'h1234_5678, 8'd0);
    send_request(OP_ARM_STEP, 32'h0000_0000, 8'd0);   // armed twice
    send_request(OP_CHECK,    32'hDEAD_BEEF, 8'd0);   // step fires, flag drops
    send_request(OP_CHECK,    32'hDEAD_BEEF, 8'd0);   // step gone
    send_request(OP_REM_ADDR, 32'h5555_AAAA, 8'd0);   // unknown address
    send_request(OP_REM_SLOT, 32'h0000_0000, 8'hFF);  // far out of range
    send_request(OP_REM_SLOT, 32'h0000_0000, 8'(NUM_SLOTS));
    send_request(OP_REM_SLOT, 32'h0000_0000, 8'(NUM_SLOTS - 1)); // unused slot
    send_request(OP_ADD,      32'hAAAA_5555, 8'd0);
    send_request(OP_REM_SLOT, 32'h0000_0000, 8'd0);   // shift entries down
    send_request(OP_CHECK,    32'hAAAA_5555, 8'd0);
    send_request(OP_REM_ADDR, 32'hFFFF_FFFF, 8'd0);
    send_request(OP_REM_ADDR, 32'hAAAA_5555, 8'd0);
    send_request(OP_REM_SLOT, 32'h0000_0000, 8'd0);   // table already empty, not set
    send_request(3'd5,        32'hFFFF_FFFF, 8'hFF);  // unused codes
    send_request(3'd6,        32'h0000_0000, 8'd0);
    send_request(3'd7,        32'h0F0F_F0F0, 8'h5A);
    wait_drained();

    // Fill: adds dominate, so the table reaches full and rejects.
    refresh_pool();
    random_phase(160, 25, 75, 83, 90, 97);
    wait_drained();

    // Mixed traffic over a fresh pool.
    refresh_pool();
    random_phase(170, 40, 62, 76, 90, 97);
    wait_drained();

    // Drain: removes dominate, so the table empties and misses pile up.
    random_phase(160, 30, 45, 70, 92, 97);

    wait_drained();
    settle = 0;
    while (settle < 5) begin
      @(posedge clk);
      settle++;
    end
    if (sb.pending() != 0) sb.report_mismatch("results left outstanding", sb.pending(), 0);

    $display("Covered %0d requests and %0d results, %0d of them hits.",
             requests_sent, sb.results_checked, sb.hits_seen);
    $display("Statuses seen: ok %0d, already set %0d, full %0d, not set %0d, range %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_ALREADY], sb.status_seen[ST_FULL],
             sb.status_seen[ST_NOT_SET], sb.status_seen[ST_RANGE]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bptm_pkg.sv
hw/rtl/bptm_cell.sv
hw/rtl/breakpoint_table_matcher_core.sv
bench/breakpoint_table_matcher_core_tb.sv
